@@ src/c_declaration_lexer_assert.svh @@
// assertion macros for the c declaration lexer checker
`ifndef C_DECLARATION_LEXER_ASSERT_SVH
`define C_DECLARATION_LEXER_ASSERT_SVH

// same-cycle implication, disabled during reset
`define CDL_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("cdl check failed");

// next-cycle implication, disabled during reset
`define CDL_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("cdl check failed");

// next-cycle implication that also watches reset itself
`define CDL_ASSERT_RST(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error("cdl check failed");

`endif

@@ src/cdl_pkg.sv @@
// shared types, token codes and keyword table of the c declaration lexer
package cdl_pkg;

    localparam int KW_COUNT            = 23;
    localparam int KW_MAXLEN           = 10;
    localparam int MAX_TOKEN_CHARS_DEF = 255;
    localparam int QUEUE_DEPTH_DEF     = 4;

    localparam logic [4:0] KIND_TEXT    = 5'd0;
    localparam logic [4:0] KIND_END     = 5'd1;
    localparam logic [4:0] KIND_ERROR   = 5'd2;
    localparam logic [4:0] KIND_PUNCT   = 5'd3;
    localparam logic [4:0] KIND_NAME    = 5'd13;
    localparam logic [4:0] KIND_NUMBER  = 5'd14;
    localparam logic [4:0] KIND_FNAME   = 5'd15;
    localparam logic [4:0] KIND_STRING  = 5'd16;
    localparam logic [4:0] KIND_KEYWORD = 5'd17;

    typedef struct packed {
        logic [4:0] kind;
        logic [7:0] ch;
        logic [4:0] idx;
        logic [7:0] len;
    } t_result;

    typedef struct packed {
        logic    two;
        t_result first;
        t_result second;
    } t_entry;

    localparam logic [79:0] KW_TEXT [KW_COUNT] = '{
        "__cdecl", "__export", "__far", "__fortran", "__huge", "__near",
        "__pascal", "__syscall", "char", "const", "double", "extern", "float",
        "int", "line", "long", "pascal", "short", "signed", "struct", "union",
        "unsigned", "void"
    };

    localparam logic [3:0] KW_LEN [KW_COUNT] = '{
        4'd7, 4'd8, 4'd5, 4'd9, 4'd6, 4'd6, 4'd8, 4'd9, 4'd4, 4'd5, 4'd6, 4'd6,
        4'd5, 4'd3, 4'd4, 4'd4, 4'd6, 4'd5, 4'd6, 4'd6, 4'd5, 4'd8, 4'd4
    };

    localparam logic [4:0] KW_INDEX [KW_COUNT] = '{
        5'd0, 5'd1, 5'd2, 5'd3, 5'd4, 5'd5, 5'd6, 5'd7, 5'd8, 5'd9, 5'd10,
        5'd11, 5'd12, 5'd13, 5'd14, 5'd15, 5'd6, 5'd16, 5'd17, 5'd18, 5'd19,
        5'd20, 5'd21
    };

    function automatic logic [7:0] kw_byte(input int k, input logic [3:0] pos);
        logic [79:0] w;
        w = KW_TEXT[k];
        if (pos >= KW_LEN[k]) begin
            return 8'h00;
        end
        return w[8 * (int'(KW_LEN[k]) - 1 - int'(pos)) +: 8];
    endfunction

    function automatic logic [KW_COUNT-1:0] kw_keep(input logic [7:0] len,
                                                    input logic [7:0] ch);
        logic [KW_COUNT-1:0] keep;
        keep = '0;
        for (int k = 0; k < KW_COUNT; k++) begin
            if (int'(len) < KW_MAXLEN && kw_byte(k, len[3:0]) == ch) begin
                keep[k] = 1'b1;
            end
        end
        return keep;
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= 8'h30 && c <= 8'h39;
    endfunction

    function automatic logic is_word(input logic [7:0] c);
        return is_alpha(c) || is_digit(c) || c == 8'h5F;
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
    endfunction

    // hit flag and position in ( ) [ ] ; * , # / .
    function automatic logic [4:0] punct_code(input logic [7:0] c);
        case (c)
            8'h28:   return {1'b1, 4'd0};
            8'h29:   return {1'b1, 4'd1};
            8'h5B:   return {1'b1, 4'd2};
            8'h5D:   return {1'b1, 4'd3};
            8'h3B:   return {1'b1, 4'd4};
            8'h2A:   return {1'b1, 4'd5};
            8'h2C:   return {1'b1, 4'd6};
            8'h23:   return {1'b1, 4'd7};
            8'h2F:   return {1'b1, 4'd8};
            8'h2E:   return {1'b1, 4'd9};
            default: return 5'd0;
        endcase
    endfunction

endpackage

@@ src/c_declaration_lexer.sv @@
// c declaration lexer top level: scanner, result queue and result sequencer
// accepts one item per cycle while the result queue has room
// first result of an item passes through the result queue and then the output register
// items with two results put them in the output register one after the other, first then second
// queue depth sets how long the scanner runs ahead of a stalled output
// synchronous active-low reset returns the scanner to the start state and empties the queue
module c_declaration_lexer #(
    parameter int MAX_TOKEN_CHARS = cdl_pkg::MAX_TOKEN_CHARS_DEF,
    parameter int QUEUE_DEPTH     = cdl_pkg::QUEUE_DEPTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [7:0] i_char_byte,
    input  logic       i_end_of_input,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [4:0] o_token_kind,
    output logic [7:0] o_text_char,
    output logic [4:0] o_keyword_index,
    output logic [7:0] o_token_length
);

    logic            take;
    logic            push;
    logic            pop;
    logic            full;
    logic            empty;
    cdl_pkg::t_entry push_entry;
    cdl_pkg::t_entry head_entry;

    assign o_in_stall = full;
    assign take       = i_in_valid && !full;

    cdl_front #(
        .MAX_TOKEN_CHARS(MAX_TOKEN_CHARS)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_take         (take),
        .i_char_byte    (i_char_byte),
        .i_end_of_input (i_end_of_input),
        .o_push         (push),
        .o_entry        (push_entry)
    );

    cdl_fifo #(
        .WIDTH($bits(cdl_pkg::t_entry)),
        .DEPTH(QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_entry),
        .i_pop   (pop),
        .o_data  (head_entry),
        .o_full  (full),
        .o_empty (empty)
    );

    cdl_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_empty         (empty),
        .i_entry         (head_entry),
        .o_pop           (pop),
        .i_out_stall     (i_out_stall),
        .o_out_valid     (o_out_valid),
        .o_token_kind    (o_token_kind),
        .o_text_char     (o_text_char),
        .o_keyword_index (o_keyword_index),
        .o_token_length  (o_token_length)
    );

endmodule

@@ src/cdl_fifo.sv @@
// small register queue between the scanner and the result sequencer
module cdl_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_full,
    output logic             o_empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr;
    logic [AW-1:0]    r_rd;
    logic [CW-1:0]    r_count;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

@@ src/cdl_front.sv @@
// scanner: classifies each character and produces up to two results per item
module cdl_front #(
    parameter int MAX_TOKEN_CHARS = cdl_pkg::MAX_TOKEN_CHARS_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_take,
    input  logic [7:0]      i_char_byte,
    input  logic            i_end_of_input,
    output logic            o_push,
    output cdl_pkg::t_entry o_entry
);

    typedef enum logic [2:0] {
        MODE_START  = 3'd0,
        MODE_NAME   = 3'd1,
        MODE_NUM    = 3'd2,
        MODE_FNAME  = 3'd3,
        MODE_STRING = 3'd4
    } t_mode;

    typedef struct packed {
        t_mode                        mode;
        logic [7:0]                   len;
        logic [cdl_pkg::KW_COUNT-1:0] cand;
        logic                         hit;
        cdl_pkg::t_result             res;
    } t_step;

    t_mode                        r_mode;
    logic [7:0]                   r_len;
    logic [cdl_pkg::KW_COUNT-1:0] r_cand;
    t_step                        n_step;
    t_step                        s;
    logic                         any;

    function automatic t_step do_accept(input t_mode m, input logic [7:0] len,
                                        input logic [cdl_pkg::KW_COUNT-1:0] cand,
                                        input logic [7:0] ch);
        t_step st;
        st      = '0;
        st.mode = m;
        st.hit  = 1'b1;
        if (len >= 8'(MAX_TOKEN_CHARS)) begin
            st.mode     = MODE_START;
            st.len      = '0;
            st.cand     = '1;
            st.res.kind = cdl_pkg::KIND_ERROR;
        end else begin
            st.cand = (m == MODE_NAME) ? (cand & cdl_pkg::kw_keep(len, ch)) : cand;
            st.len      = len + 8'd1;
            st.res.kind = cdl_pkg::KIND_TEXT;
            st.res.ch   = ch;
        end
        return st;
    endfunction

    function automatic t_step do_start(input logic [7:0] ch);
        t_step      st;
        logic [4:0] pc;
        st      = '0;
        st.mode = MODE_START;
        st.cand = '1;
        pc      = cdl_pkg::punct_code(ch);
        if (cdl_pkg::is_space(ch)) begin
            st.hit = 1'b0;
        end else if (pc[4]) begin
            st.hit      = 1'b1;
            st.res.kind = cdl_pkg::KIND_PUNCT + 5'(pc[3:0]);
            st.res.len  = 8'd1;
        end else if (ch == 8'h22) begin
            st.mode = MODE_STRING;
        end else if (ch == 8'h5C) begin
            st = do_accept(MODE_FNAME, 8'd0, '1, ch);
        end else if (ch == 8'h5F || cdl_pkg::is_alpha(ch)) begin
            st = do_accept(MODE_NAME, 8'd0, '1, ch);
        end else if (cdl_pkg::is_digit(ch)) begin
            st = do_accept(MODE_NUM, 8'd0, '1, ch);
        end else begin
            st.hit      = 1'b1;
            st.res.kind = cdl_pkg::KIND_ERROR;
        end
        return st;
    endfunction

    function automatic cdl_pkg::t_result do_finish(input t_mode m, input logic [7:0] len,
                                                   input logic [cdl_pkg::KW_COUNT-1:0] cand);
        cdl_pkg::t_result r;
        r      = '0;
        r.kind = cdl_pkg::KIND_FNAME;
        r.len  = len;
        if (m == MODE_NUM) begin
            r.kind = cdl_pkg::KIND_NUMBER;
        end else if (m == MODE_NAME) begin
            r.kind = cdl_pkg::KIND_NAME;
            for (int k = 0; k < cdl_pkg::KW_COUNT; k++) begin
                if (cand[k] && 8'(cdl_pkg::KW_LEN[k]) == len) begin
                    r.kind = cdl_pkg::KIND_KEYWORD;
                    r.idx  = cdl_pkg::KW_INDEX[k];
                end
            end
        end
        return r;
    endfunction

    always_comb begin
        n_step       = '0;
        n_step.mode  = MODE_START;
        n_step.cand  = '1;
        o_entry      = '0;
        any          = 1'b0;
        s            = do_start(i_char_byte);
        if (i_end_of_input) begin
            any = 1'b1;
            if (r_mode == MODE_NAME || r_mode == MODE_NUM || r_mode == MODE_FNAME) begin
                o_entry.first       = do_finish(r_mode, r_len, r_cand);
                o_entry.second.kind = cdl_pkg::KIND_END;
                o_entry.two         = 1'b1;
            end else if (r_mode == MODE_STRING) begin
                o_entry.first.kind  = cdl_pkg::KIND_ERROR;
                o_entry.second.kind = cdl_pkg::KIND_END;
                o_entry.two         = 1'b1;
            end else begin
                o_entry.first.kind = cdl_pkg::KIND_END;
            end
        end else begin
            case (r_mode)
                MODE_NAME, MODE_NUM, MODE_FNAME: begin
                    if ((r_mode == MODE_NUM) ? cdl_pkg::is_digit(i_char_byte)
                                             : cdl_pkg::is_word(i_char_byte)) begin
                        n_step = do_accept(r_mode, r_len, r_cand, i_char_byte);
                        any    = 1'b1;
                    end else if (cdl_pkg::is_word(i_char_byte)
                                 || i_char_byte inside {8'h2E, 8'h5C}
                                 || (i_char_byte == 8'h3A && r_mode != MODE_NUM)) begin
                        n_step = do_accept(MODE_FNAME, r_len, r_cand, i_char_byte);
                        any    = 1'b1;
                    end else begin
                        o_entry.first  = do_finish(r_mode, r_len, r_cand);
                        o_entry.second = s.res;
                        o_entry.two    = s.hit;
                        n_step         = s;
                        any            = 1'b1;
                    end
                    if (any && !o_entry.two && o_entry.first.kind == cdl_pkg::KIND_TEXT
                        && o_entry.first.len == '0) begin
                        o_entry.first = n_step.res;
                    end
                end
                MODE_STRING: begin
                    any = 1'b1;
                    if (i_char_byte == 8'h22) begin
                        o_entry.first.kind = cdl_pkg::KIND_STRING;
                        o_entry.first.len  = r_len;
                    end else begin
                        n_step        = do_accept(MODE_STRING, r_len, r_cand, i_char_byte);
                        o_entry.first = n_step.res;
                    end
                end
                default: begin
                    n_step        = s;
                    o_entry.first = s.res;
                    any           = s.hit;
                end
            endcase
        end
    end

    assign o_push = i_take && any;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_START;
            r_len  <= '0;
            r_cand <= '1;
        end else if (i_take) begin
            r_mode <= n_step.mode;
            r_len  <= n_step.len;
            r_cand <= n_step.cand;
        end
    end

endmodule

@@ src/cdl_back.sv @@
// result sequencer: drains queued entries one result per cycle into the output register while the output is not stalled
module cdl_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_empty,
    input  cdl_pkg::t_entry i_entry,
    output logic            o_pop,
    input  logic            i_out_stall,
    output logic            o_out_valid,
    output logic [4:0]      o_token_kind,
    output logic [7:0]      o_text_char,
    output logic [4:0]      o_keyword_index,
    output logic [7:0]      o_token_length
);

    logic             r_valid;
    logic             r_pend;
    cdl_pkg::t_result r_res;
    cdl_pkg::t_result r_second;
    logic             out_free;

    assign out_free = !r_valid || !i_out_stall;
    assign o_pop    = out_free && !r_pend && !i_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_pend  <= 1'b0;
        end else if (out_free) begin
            if (r_pend) begin
                r_res   <= r_second;
                r_valid <= 1'b1;
                r_pend  <= 1'b0;
            end else if (!i_empty) begin
                r_res    <= i_entry.first;
                r_second <= i_entry.second;
                r_pend   <= i_entry.two;
                r_valid  <= 1'b1;
            end else begin
                r_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid     = r_valid;
    assign o_token_kind    = r_res.kind;
    assign o_text_char     = r_res.ch;
    assign o_keyword_index = r_res.idx;
    assign o_token_length  = r_res.len;

endmodule

@@ src/cdl_checker.sv @@
// port-level checker for the c declaration lexer and its bind
`include "c_declaration_lexer_assert.svh"

module cdl_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       o_in_stall,
    input logic [7:0] i_char_byte,
    input logic       i_end_of_input,
    input logic       o_out_valid,
    input logic       i_out_stall,
    input logic [4:0] o_token_kind,
    input logic [7:0] o_text_char,
    input logic [4:0] o_keyword_index,
    input logic [7:0] o_token_length
);

    `CDL_ASSERT_NEXT(a_out_hold, o_out_valid && i_out_stall, o_out_valid && $stable(o_token_kind) && $stable(o_text_char) && $stable(o_keyword_index) && $stable(o_token_length))
    `CDL_ASSERT_RST(a_reset_clears, !i_rst_n, !o_out_valid && !o_in_stall)
    `CDL_ASSERT_NOW(a_idle_not_stalled, !o_out_valid, !o_in_stall)
    `CDL_ASSERT_NOW(a_char_only_text, o_out_valid && o_token_kind != cdl_pkg::KIND_TEXT, o_text_char == 8'h00)

endmodule

bind c_declaration_lexer cdl_checker u_cdl_checker (.*);
